// ===== hdl/assert_macros.svh =====
// Assertion macros for the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked at every clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== hdl/wbps_pkg.sv =====
// Types and constants of the wildcard byte pattern search.
package wbps_pkg;

    localparam int MAX_PATTERN    = 16;
    localparam int WINDOW_DEPTH   = MAX_PATTERN - 1;
    localparam int LEN_W          = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W          = $clog2(MAX_PATTERN);
    localparam int OFFSET_BITS    = 32;
    localparam int MATCH_OFFSET_W = 32;
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_LEN_W      = 5;
    localparam int CFG_MASK_W     = 16;

    typedef enum logic [1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_WILDCARD_MASK  = 2'd2,
        CFG_PATTERN_LENGTH = 2'd3
    } cfg_reg_e;

    // Signature as seen by the compare cells; len is already clamped to 1..MAX_PATTERN.
    typedef struct packed {
        logic [MAX_PATTERN-1:0][7:0] bytes;
        logic [MAX_PATTERN-1:0]      wild;
        logic [LEN_W-1:0]            len;
    } sig_cfg_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

endpackage

// ===== hdl/wbps_cell.sv =====
// One window stage: holds a past byte and compares it to its signature byte.
module wbps_cell (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  wbps_pkg::cell_ctl_t      ctl,
    input  wbps_pkg::sig_cfg_t       sig,
    input  logic [wbps_pkg::IDX_W-1:0] cell_index,
    input  logic [7:0]               byte_in,
    input  logic                     valid_in,
    output logic [7:0]               byte_out,
    output logic                     valid_out,
    output logic                     match_ok
);

    logic [7:0]                 byte_reg, byte_next;
    logic                       valid_reg, valid_next;
    logic [wbps_pkg::LEN_W-1:0] sel_full;
    logic [wbps_pkg::IDX_W-1:0] sel;
    logic                       active;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    always_comb begin
        priority if (ctl.clear) begin
            valid_next = 1'b0;
        end else if (ctl.shift) begin
            valid_next = valid_in;
        end else begin
            valid_next = valid_reg;
        end
        byte_next = ctl.shift ? byte_in : byte_reg;
    end

    // stage k holds the byte k+1 places back; it lines up with signature byte len-2-k
    always_comb begin
        active   = ((wbps_pkg::LEN_W'(cell_index) + wbps_pkg::LEN_W'(2)) <= sig.len);
        sel_full = sig.len - wbps_pkg::LEN_W'(cell_index) - wbps_pkg::LEN_W'(2);
        sel      = sel_full[wbps_pkg::IDX_W-1:0];
        match_ok = !active || (valid_reg && (sig.wild[sel] || (byte_reg == sig.bytes[sel])));
    end

    assign byte_out  = byte_reg;
    assign valid_out = valid_reg;

endmodule

// ===== hdl/wildcard_byte_pattern_search.sv =====
// Top level of the wildcard byte pattern search.
//
//  channel  direction  tdata               tuser    tlast
//  s_       in         data_byte[7:0]      -        last_byte
//  m_       out        match_offset[31:0]  found    -
//  cfg_     in         write, index 0..3   -        -
//
// One byte per cycle while s_tready is high; the match result is registered and shows in
// the cycle after the byte that completes it. The window is a chain of byte stages with one
// compare each plus the compare of the incoming byte.
// aresetn clears the window, counter, flags and registers (pattern_length to 1).
// s_tready drops only while a result waits and m_tready is low.
module wildcard_byte_pattern_search (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] data_byte
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [wbps_pkg::MATCH_OFFSET_W-1:0] m_tdata,   // [31:0] match_offset
    output logic                                m_tuser,   // [0] found
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int WD = wbps_pkg::WINDOW_DEPTH;
    localparam int OB = wbps_pkg::OFFSET_BITS;

    logic [63:0]                       pattern_low_reg;
    logic [63:0]                       pattern_high_reg;
    logic [wbps_pkg::CFG_MASK_W-1:0]   wildcard_reg;
    logic [wbps_pkg::CFG_LEN_W-1:0]    length_reg;

    logic [OB-1:0]                     bytes_seen_reg, bytes_seen_next;
    logic                              reported_reg, reported_next;
    logic                              m_valid_reg, m_valid_next;
    logic [wbps_pkg::MATCH_OFFSET_W-1:0] m_offset_reg, m_offset_next;
    logic                              m_found_reg, m_found_next;

    wbps_pkg::sig_cfg_t                sig;
    wbps_pkg::cell_ctl_t               ctl;
    wbps_pkg::cfg_reg_e                cfg_sel;

    logic [7:0]                        win_byte  [WD+1];
    logic                              win_valid [WD+1];
    logic [WD-1:0]                     cell_ok;

    logic [wbps_pkg::IDX_W-1:0]        head_sel;
    logic                              head_ok;
    logic                              hit;
    logic                              emit;
    logic                              accept_in;
    logic [OB-1:0]                     offset;

    // configuration registers
    assign cfg_sel = wbps_pkg::cfg_reg_e'(cfg_index);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            wildcard_reg     <= '0;
            length_reg       <= wbps_pkg::CFG_LEN_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_sel)
                wbps_pkg::CFG_PATTERN_LOW:    pattern_low_reg  <= cfg_data[63:0];
                wbps_pkg::CFG_PATTERN_HIGH:   pattern_high_reg <= cfg_data[63:0];
                wbps_pkg::CFG_WILDCARD_MASK:  wildcard_reg     <= cfg_data[wbps_pkg::CFG_MASK_W-1:0];
                wbps_pkg::CFG_PATTERN_LENGTH: length_reg       <= cfg_data[wbps_pkg::CFG_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        sig.bytes = (wbps_pkg::MAX_PATTERN * 8)'({pattern_high_reg, pattern_low_reg});
        sig.wild  = wbps_pkg::MAX_PATTERN'(wildcard_reg);
        priority if (length_reg == '0) begin
            sig.len = wbps_pkg::LEN_W'(1);
        end else if (wbps_pkg::LEN_W'(length_reg) > wbps_pkg::LEN_W'(wbps_pkg::MAX_PATTERN)) begin
            sig.len = wbps_pkg::LEN_W'(wbps_pkg::MAX_PATTERN);
        end else begin
            sig.len = wbps_pkg::LEN_W'(length_reg);
        end
    end

    // window chain
    assign s_tready  = !m_valid_reg || m_tready;
    assign accept_in = s_tvalid && s_tready;
    assign ctl.shift = accept_in && !s_tlast;
    assign ctl.clear = accept_in && s_tlast;

    assign win_byte[0]  = s_tdata[7:0];
    assign win_valid[0] = 1'b1;

    for (genvar k = 0; k < WD; k++) begin : g_cell
        wbps_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .sig        (sig),
            .cell_index (wbps_pkg::IDX_W'(k)),
            .byte_in    (win_byte[k]),
            .valid_in   (win_valid[k]),
            .byte_out   (win_byte[k+1]),
            .valid_out  (win_valid[k+1]),
            .match_ok   (cell_ok[k])
        );
    end

    // incoming byte against the last signature byte, then result
    always_comb begin
        head_sel = wbps_pkg::IDX_W'(sig.len - wbps_pkg::LEN_W'(1));
        head_ok  = sig.wild[head_sel] || (s_tdata[7:0] == sig.bytes[head_sel]);
        hit      = !reported_reg && head_ok && (&cell_ok);
        emit     = hit || (s_tlast && !reported_reg);
        if (&bytes_seen_reg) begin
            offset = bytes_seen_reg;
        end else begin
            offset = bytes_seen_reg - (OB'(sig.len) - OB'(1));
        end
    end

    always_comb begin
        bytes_seen_next = bytes_seen_reg;
        reported_next   = reported_reg;
        if (accept_in) begin
            if (s_tlast) begin
                bytes_seen_next = '0;
                reported_next   = 1'b0;
            end else begin
                if (!(&bytes_seen_reg)) begin
                    bytes_seen_next = bytes_seen_reg + OB'(1);
                end
                if (hit) begin
                    reported_next = 1'b1;
                end
            end
        end
    end

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_found_next  = m_found_reg;
        m_offset_next = m_offset_reg;
        if (accept_in && emit) begin
            m_valid_next  = 1'b1;
            m_found_next  = hit;
            m_offset_next = hit ? wbps_pkg::MATCH_OFFSET_W'(offset) : '0;
        end else if (m_tready) begin
            m_valid_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_seen_reg <= '0;
            reported_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            bytes_seen_reg <= bytes_seen_next;
            reported_reg   <= reported_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_found_reg  <= m_found_next;
        m_offset_reg <= m_offset_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_offset_reg;
    assign m_tuser  = m_found_reg;

endmodule

// ===== hdl/wbps_checker.sv =====
// Port checker for the wildcard byte pattern search, bound to the top level.
`include "assert_macros.svh"

module wbps_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [wbps_pkg::MATCH_OFFSET_W-1:0] m_tdata,
    input logic                                m_tuser
);

    // result held until taken
    `ASSERT_CLK(a_m_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)
    `ASSERT_CLK(a_m_stable, aclk, aresetn, m_tvalid && !m_tready |=> $stable({m_tdata, m_tuser}))
    // a waiting transaction stalls the input side
    `ASSERT_CLK(a_backpressure, aclk, aresetn, m_tvalid && !m_tready |-> !s_tready)
    `ASSERT_CLK_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid)

endmodule

bind wildcard_byte_pattern_search wbps_checker u_wbps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== sim/wildcard_byte_pattern_search_checker.sv =====
// Checker: predicts scan reports from the observed transactions and compares them.
module wildcard_byte_pattern_search_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [7:0]                          s_tdata,
    input  logic                                s_tlast,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [wbps_pkg::MATCH_OFFSET_W-1:0] m_tdata,
    input  logic                                m_tuser,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                  error_count,
    output int                                  awaited
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                                found;
        logic [wbps_pkg::MATCH_OFFSET_W-1:0] offset;
    } scan_report_t;

    logic [wbps_pkg::MAX_PATTERN*8-1:0] sig_bytes;
    logic [wbps_pkg::CFG_MASK_W-1:0]    sig_wild;
    logic [wbps_pkg::CFG_LEN_W-1:0]     sig_len;

    logic [7:0]                       history [wbps_pkg::WINDOW_DEPTH];  // newest first
    logic [wbps_pkg::OFFSET_BITS-1:0] byte_count;
    logic                             reported;

    scan_report_t report_q [$];
    int           errors;

    function void clear_scan();
        history    = '{default: '0};
        byte_count = '0;
        reported   = 1'b0;
    endfunction

    function void scan_byte(input logic [7:0] cur, input logic last);
        int                               n;
        logic                             hit;
        logic [7:0]                       b;
        logic [wbps_pkg::OFFSET_BITS-1:0] at;
        n = (sig_len == 0) ? 1 : ((sig_len > wbps_pkg::MAX_PATTERN) ?
            wbps_pkg::MAX_PATTERN : int'(sig_len));
        if (!reported && byte_count >= n - 1) begin
            hit = 1'b1;
            for (int j = 0; j < n; j++) begin
                if (j == n - 1) begin
                    b = cur;
                end else begin
                    b = history[n - 2 - j];
                end
                if (!sig_wild[j] && b != sig_bytes[8*j +: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                at = (byte_count == '1) ? '1 : byte_count - (n - 1);
                report_q.insert(report_q.size(),
                    scan_report_t'{found: 1'b1, offset: wbps_pkg::MATCH_OFFSET_W'(at)});
                reported = 1'b1;
            end
        end
        if (last) begin
            if (!reported) begin
                report_q.insert(report_q.size(), scan_report_t'{found: 1'b0, offset: '0});
            end
            clear_scan();
        end else begin
            for (int j = wbps_pkg::WINDOW_DEPTH - 1; j > 0; j--) begin
                history[j] = history[j - 1];
            end
            history[0] = cur;
            if (byte_count != '1) begin
                byte_count++;
            end
        end
    endfunction

    always @(posedge aclk) begin
        scan_report_t want;
        if (!aresetn) begin
            sig_bytes = '0;
            sig_wild  = '0;
            sig_len   = 1;
            clear_scan();
            report_q.delete();
            errors = 0;
        end else begin
            if (cfg_we) begin
                unique case (wbps_pkg::cfg_reg_e'(cfg_index))
                    wbps_pkg::CFG_PATTERN_LOW:    sig_bytes[63:0]   = cfg_data;
                    wbps_pkg::CFG_PATTERN_HIGH:   sig_bytes[127:64] = cfg_data;
                    wbps_pkg::CFG_WILDCARD_MASK:
                        sig_wild = cfg_data[wbps_pkg::CFG_MASK_W-1:0];
                    wbps_pkg::CFG_PATTERN_LENGTH:
                        sig_len = cfg_data[wbps_pkg::CFG_LEN_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (report_q.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none, actual found=%0d offset=%0d",
                             $time, m_tuser, m_tdata);
                    errors++;
                end else begin
                    want = report_q.pop_front();
                    if (m_tuser !== want.found) begin
                        $display("%0t: found expected %0d, actual %0d",
                                 $time, want.found, m_tuser);
                        errors++;
                    end
                    if (m_tdata !== want.offset) begin
                        $display("%0t: match_offset expected %0d, actual %0d",
                                 $time, want.offset, m_tdata);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                scan_byte(s_tdata, s_tlast);
            end
        end
        awaited     <= report_q.size();
        error_count <= errors;
    end

endmodule

// ===== sim/wildcard_byte_pattern_search_tb.sv =====
// Testbench top: stimulus, handshake pressure and verdict for the pattern search.
module wildcard_byte_pattern_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1850;

    logic                                  aclk      = 1'b0;
    logic                                  aresetn   = 1'b0;
    logic                                  s_tvalid  = 1'b0;
    logic [7:0]                            s_tdata   = '0;
    logic                                  s_tlast   = 1'b0;
    logic                                  m_tready  = 1'b0;
    logic                                  cfg_we    = 1'b0;
    logic [1:0]                            cfg_index = '0;
    logic [wbps_pkg::CFG_DATA_W-1:0]       cfg_data  = '0;
    logic                                  s_tready;
    logic                                  m_tvalid;
    logic [wbps_pkg::MATCH_OFFSET_W-1:0]   m_tdata;
    logic                                  m_tuser;
    int                                    error_count;
    int                                    awaited;

    int send_gap_pct = 0;
    int stall_pct    = 0;
    int items_sent   = 0;

    // copy of the signature currently loaded, used to build images
    logic [127:0] sig_bytes;
    logic [15:0]  sig_wild;
    int           sig_n;

    wildcard_byte_pattern_search u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wildcard_byte_pattern_search_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .error_count (error_count),
        .awaited     (awaited)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        #1_000_000;
        $display("wildcard_byte_pattern_search_tb: errors");
        $finish;
    end

    task automatic push_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_bytes(input logic [7:0] img [$], input bit close);
        foreach (img[i]) begin
            push_byte(img[i], close && (i == img.size() - 1));
        end
        items_sent += img.size();
    endtask

    // wait until every expected report is out and any byte in flight has settled
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaited != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_signature(input logic [127:0] pat, input logic [15:0] wild,
                                  input logic [4:0] len_code);
        logic [63:0]        vals [4];
        wbps_pkg::cfg_reg_e regs [4] = '{wbps_pkg::CFG_PATTERN_LOW,
                                         wbps_pkg::CFG_PATTERN_HIGH,
                                         wbps_pkg::CFG_WILDCARD_MASK,
                                         wbps_pkg::CFG_PATTERN_LENGTH};
        vals[0] = pat[63:0];
        vals[1] = pat[127:64];
        vals[2] = {$urandom, $urandom};
        vals[2][15:0] = wild;
        vals[3] = {$urandom, $urandom};
        vals[3][4:0] = len_code;
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge aclk);
        end
        cfg_we    <= 1'b0;
        sig_bytes = pat;
        sig_wild  = wild;
        sig_n     = (len_code == 0) ? 1 : ((len_code > 16) ? 16 : int'(len_code));
    endtask

    task automatic random_signature();
        logic [127:0] pat;
        logic [15:0]  wild;
        logic [4:0]   code;
        int           r;
        pat = {$urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(3) == 0) begin
            pat = {16{8'h5A}};  // self-overlapping signature
        end
        r = $urandom_range(9);
        unique case (r)
            0:       code = 5'd0;
            1:       code = 5'($urandom_range(31, 17));
            2:       code = 5'd16;
            3:       code = 5'd1;
            default: code = 5'($urandom_range(16, 1));
        endcase
        r = $urandom_range(7);
        unique case (r)
            0:       wild = 16'h0000;
            1:       wild = 16'hFFFF;
            default: wild = 16'($urandom & $urandom & $urandom);
        endcase
        load_signature(pat, wild, code);
    endtask

    function automatic logic [7:0] noise_byte();
        int k;
        k = $urandom_range(sig_n - 1);
        if ($urandom_range(1) == 0) begin
            return sig_bytes[8*k +: 8];
        end
        return 8'($urandom);
    endfunction

    // one image: noise, then mostly a signature copy (some with a flipped byte), then noise
    task automatic run_image(input bit close);
        logic [7:0] img [$];
        logic [7:0] b;
        int         kind;
        int         pre;
        int         flip;
        kind = $urandom_range(9);
        pre  = ($urandom_range(15) == 0) ? $urandom_range(300) : $urandom_range(24);
        repeat (pre) img.insert(img.size(), noise_byte());
        if (kind < 7) begin
            flip = (kind >= 5) ? $urandom_range(sig_n - 1) : -1;
            for (int j = 0; j < sig_n; j++) begin
                b = sig_wild[j] ? 8'($urandom) : sig_bytes[8*j +: 8];
                if (j == flip) begin
                    b ^= 8'(1 << $urandom_range(7));
                end
                img.insert(img.size(), b);
            end
        end
        repeat ($urandom_range(8)) img.insert(img.size(), noise_byte());
        if (img.size() == 0) begin
            img.insert(img.size(), noise_byte());
        end
        send_bytes(img, close);
    endtask

    initial begin
        logic [7:0] img [$];
        int         phase;
        int         target;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // length zero acts as one
        load_signature(128'hFF, 16'h0000, 5'd0);
        send_bytes({8'h00, 8'hFF}, 1'b1);
        settle();
        // sliding start, bytes after the match, then an image shorter than the signature
        load_signature(128'hEF00ADDE, 16'h0004, 5'd4);
        send_bytes({8'hDE, 8'hDE, 8'hAD, 8'h55, 8'hEF, 8'h00}, 1'b1);
        send_bytes({8'hDE, 8'hAD}, 1'b1);
        settle();
        // oversized length saturates; all wildcards; match on the final byte
        load_signature({16{8'h3C}}, 16'hFFFF, 5'd31);
        for (int j = 0; j < 16; j++) begin
            img.insert(img.size(), (j % 2) ? 8'hFF : 8'h00);
        end
        send_bytes(img, 1'b1);

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            settle();
            unique case (phase % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 68; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 68; end
                default: begin send_gap_pct = 11; stall_pct = 11; end
            endcase
            random_signature();
            target = items_sent + 100 + $urandom_range(60);
            while (items_sent < target) run_image(1'b1);
            // leave a scan open so the next register writes land mid-image
            if ($urandom_range(2) == 0) begin
                run_image(1'b0);
            end
            phase++;
        end
        settle();
        if (error_count == 0) begin
            $display("wildcard_byte_pattern_search_tb: clean");
        end else begin
            $display("wildcard_byte_pattern_search_tb: errors");
        end
        $finish;
    end

endmodule

// ===== wildcard_byte_pattern_search.f =====
+incdir+hdl
hdl/wbps_pkg.sv
hdl/wbps_cell.sv
hdl/wildcard_byte_pattern_search.sv
hdl/wbps_checker.sv
sim/wildcard_byte_pattern_search_checker.sv
sim/wildcard_byte_pattern_search_tb.sv
